/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the fft engine RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FFE_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FFE_ASSERT(lbl, clk, rstn, prop, msg)
`define FFE_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* design/fftfe_pkg.sv */
// ---------------------------------------------------------------------------
// fftfe_pkg
// Types, command codes and fixed-point helpers of the fft filter engine.
// ---------------------------------------------------------------------------
package fftfe_pkg;

  localparam int FFT_POINTS     = 1024;
  localparam int FFT_LOG_POINTS = 10;

  localparam int          Q15_SHIFT         = 15;
  localparam int          SAMPLE_SHIFT      = 4;
  localparam logic [15:0] Q15_ONE           = 16'd32767;
  localparam logic [48:0] ROUND_CONST       = 49'd16384;
  localparam logic [11:0] SAMPLE_OFFSET_RST = 12'd2048;
  localparam real         TWO_PI            = 6.283185307179586;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_FWD   = 3'd1;
  localparam logic [2:0] OP_FILT  = 3'd2;
  localparam logic [2:0] OP_INV   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_COEF  = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PERM,
    ST_BFLY,
    ST_FILT,
    ST_SCALE
  } fftfe_state_t;

  // q15 product rounding: add half an lsb, arithmetic shift, keep 32 bits
  function automatic logic [31:0] q15_round(input logic signed [48:0] p);
    logic signed [48:0] s;
    s = p + ROUND_CONST;
    return s[Q15_SHIFT+31:Q15_SHIFT];
  endfunction

endpackage

/* design/fixed_point_fft_filter_engine.sv */
// ---------------------------------------------------------------------------
// fixed_point_fft_filter_engine
// In-place radix-2 dit fft with per-bin q15 filter and inverse transform,
// spectrum and time data held in single-port-read / single-port-write rams.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | start / busy         | in_op, in_index, in_sample_word, in_coefficient
//  result   | out_valid (strobe)   | out_bin_index, out_real_part, out_imag_part,
//           |                      | out_time_value
//  config   | apb psel/penable     | paddr, pwdata, prdata
//
// load, read and coefficient words may follow every cycle while busy is low;
// a read word shows its result in the cycle after acceptance.
// forward: bit reversal visits every position and swaps each pair in three
// further steps, then the butterfly stages run over all pairs (one butterfly
// walks the single ram port in five steps); inverse adds a scaling pass;
// filter passes once over every bin. busy is high meanwhile.
// after reset the gain ram is swept to q15 one with busy high.
// the result side cannot stall; results are shown for exactly one cycle.
`include "assert_macros.svh"

module fixed_point_fft_filter_engine #(
  parameter int POINTS     = fftfe_pkg::FFT_POINTS,
  parameter int LOG_POINTS = fftfe_pkg::FFT_LOG_POINTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_op,
  input  logic [LOG_POINTS-1:0] in_index,
  input  logic [15:0]           in_sample_word,
  input  logic signed [15:0]    in_coefficient,
  output logic                  out_valid,
  output logic [LOG_POINTS-1:0] out_bin_index,
  output logic signed [31:0]    out_real_part,
  output logic signed [31:0]    out_imag_part,
  output logic signed [31:0]    out_time_value,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import fftfe_pkg::*;

  localparam int LW = LOG_POINTS;
  localparam int SW = $clog2(LOG_POINTS);

  typedef logic signed [15:0] rom_t [POINTS];

  function automatic rom_t build_rom();
    rom_t   t;
    int     q;
    int     m;
    int     v;
    real    sc;
    real    c;
    logic   neg;
    sc = 1.0;
    for (int i = 0; i < LOG_POINTS; i++) sc = sc * 0.5;
    q = POINTS / 4;
    for (int j = 0; j < POINTS; j++) begin
      if (j <= q) begin
        m = j; neg = 1'b0;
      end else if (j <= 2 * q) begin
        m = 2 * q - j; neg = 1'b1;
      end else if (j <= 3 * q) begin
        m = j - 2 * q; neg = 1'b1;
      end else begin
        m = POINTS - j; neg = 1'b0;
      end
      c = $cos(TWO_PI * m * sc) * 32767.0;
      v = int'($floor(c + 0.5));
      if (v < 0) v = 0;
      if (neg) v = -v;
      t[j] = 16'(v);
    end
    return t;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // storage
  logic [31:0] real_mem [POINTS];
  logic [31:0] imag_mem [POINTS];
  logic [31:0] time_mem [POINTS];
  logic [15:0] gain_mem [POINTS];

  fftfe_state_t st_r, st_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [SW-1:0] stg_r, stg_nxt;
  logic          inv_r, inv_nxt;
  logic          out_pend_r;
  logic [LW-1:0] out_idx_r;
  logic [11:0]   sample_offset_r;

  logic [31:0] re_rd_r, im_rd_r, tm_rd_r;
  logic [15:0] gn_rd_r;
  logic signed [15:0] rom_c_r, rom_s_r;
  logic [31:0] ur_r, ui_r, tr_r, ti_r;
  logic signed [48:0] p_a_r, p_b_r, p_c_r, p_d_r;

  logic [LW-1:0] raddr, waddr;
  logic          re_we, im_we, tm_we, gn_we;
  logic [31:0]   re_wd, im_wd, tm_wd;
  logic [15:0]   gn_wd;
  logic          rom_en, cap_u, cap_p, cap_t;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (st_r != ST_IDLE);

  // index helpers
  logic [LW-1:0] rev;
  always_comb begin
    for (int i = 0; i < LW; i++) rev[i] = cnt_r[LW-1-i];
  end

  logic [LW-1:0] low_mask, bf_a, bf_b, tw_c, tw_s;
  logic [LW:0]   a_ext;
  always_comb begin
    low_mask = (LW'(1) << stg_r) - LW'(1);
    a_ext    = (({1'b0, cnt_r} >> stg_r) << ({1'b0, stg_r} + (SW+1)'(1)))
             | {1'b0, cnt_r & low_mask};
    bf_a     = a_ext[LW-1:0];
    bf_b     = bf_a | (LW'(1) << stg_r);
    tw_c     = (cnt_r & low_mask) << (SW'(LOG_POINTS - 1) - stg_r);
    tw_s     = tw_c + LW'(3 * POINTS / 4);
  end

  logic last_cnt, last_bf, last_stg, swap;
  logic perm_adv, bf_adv, filt_adv, scale_adv;
  assign last_cnt  = (cnt_r == LW'(POINTS - 1));
  assign last_bf   = (cnt_r == LW'(POINTS / 2 - 1));
  assign last_stg  = (stg_r == SW'(LOG_POINTS - 1));
  assign swap      = (rev > cnt_r);
  assign perm_adv  = (ph_r == 3'd3) || (ph_r == 3'd0 && !swap);
  assign bf_adv    = (ph_r == 3'd4);
  assign filt_adv  = (ph_r == 3'd2);
  assign scale_adv = (ph_r == 3'd1);

  // arithmetic
  logic signed [16:0] wr, wi, gn, w1, w2;
  logic signed [48:0] mul_a, mul_b, mul_c, mul_d;
  logic [31:0] rnd_a, rnd_b, rnd_c, rnd_d, tr, ti, load_val, div_val;
  logic [32:0] div_sum;
  always_comb begin
    wr    = {rom_c_r[15], rom_c_r};
    wi    = inv_r ? {rom_s_r[15], rom_s_r} : -{rom_s_r[15], rom_s_r};
    gn    = {gn_rd_r[15], gn_rd_r};
    w1    = (st_r == ST_BFLY) ? wr : gn;
    w2    = (st_r == ST_BFLY) ? wi : gn;
    mul_a = $signed(re_rd_r) * w1;
    mul_b = $signed(im_rd_r) * w2;
    mul_c = $signed(re_rd_r) * wi;
    mul_d = $signed(im_rd_r) * wr;
    rnd_a = q15_round(p_a_r);
    rnd_b = q15_round(p_b_r);
    rnd_c = q15_round(p_c_r);
    rnd_d = q15_round(p_d_r);
    tr    = rnd_a - rnd_b;
    ti    = rnd_c + rnd_d;
    load_val = {20'd0, in_sample_word[15:SAMPLE_SHIFT]} - {20'd0, sample_offset_r};
    // divide by POINTS toward zero: bias negatives before the shift
    div_sum  = {re_rd_r[31], re_rd_r}
             + (re_rd_r[31] ? 33'(POINTS - 1) : 33'd0);
    div_val  = 32'($signed(div_sum) >>> LOG_POINTS);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (last_cnt) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && (in_op == OP_FWD || in_op == OP_INV)) st_nxt = ST_PERM;
        else if (accept && in_op == OP_FILT) st_nxt = ST_FILT;
      end
      ST_PERM: if (perm_adv && last_cnt) st_nxt = ST_BFLY;
      ST_BFLY: begin
        if (bf_adv && last_bf && last_stg) st_nxt = inv_r ? ST_SCALE : ST_IDLE;
      end
      ST_FILT:  if (filt_adv && last_cnt) st_nxt = ST_IDLE;
      ST_SCALE: if (scale_adv && last_cnt) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cnt_nxt = cnt_r;
    ph_nxt  = ph_r;
    stg_nxt = stg_r;
    inv_nxt = inv_r;
    raddr   = cnt_r;
    waddr   = cnt_r;
    re_we   = 1'b0;
    im_we   = 1'b0;
    tm_we   = 1'b0;
    gn_we   = 1'b0;
    re_wd   = re_rd_r;
    im_wd   = im_rd_r;
    tm_wd   = div_val;
    gn_wd   = Q15_ONE;
    rom_en  = 1'b0;
    cap_u   = 1'b0;
    cap_p   = 1'b0;
    cap_t   = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        gn_we   = 1'b1;
        cnt_nxt = cnt_r + LW'(1);
      end
      ST_IDLE: begin
        raddr   = in_index;
        waddr   = in_index;
        cnt_nxt = '0;
        ph_nxt  = 3'd0;
        stg_nxt = '0;
        if (accept) begin
          case (in_op)
            OP_LOAD: begin
              re_we = 1'b1;
              im_we = 1'b1;
              re_wd = load_val;
              im_wd = '0;
            end
            OP_COEF: begin
              gn_we = 1'b1;
              gn_wd = in_coefficient;
            end
            OP_FWD:  inv_nxt = 1'b0;
            OP_INV:  inv_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PERM: begin
        case (ph_r)
          3'd0: begin
            if (swap) ph_nxt = 3'd1;
            else cnt_nxt = cnt_r + LW'(1);
          end
          3'd1: begin
            raddr  = rev;
            cap_u  = 1'b1;
            ph_nxt = 3'd2;
          end
          3'd2: begin
            re_we  = 1'b1;
            im_we  = 1'b1;
            ph_nxt = 3'd3;
          end
          3'd3: begin
            waddr   = rev;
            re_we   = 1'b1;
            im_we   = 1'b1;
            re_wd   = ur_r;
            im_wd   = ui_r;
            ph_nxt  = 3'd0;
            cnt_nxt = cnt_r + LW'(1);
          end
          default: ph_nxt = 3'd0;
        endcase
      end
      ST_BFLY: begin
        case (ph_r)
          3'd0: begin
            raddr  = bf_a;
            rom_en = 1'b1;
            ph_nxt = 3'd1;
          end
          3'd1: begin
            raddr  = bf_b;
            cap_u  = 1'b1;
            ph_nxt = 3'd2;
          end
          3'd2: begin
            cap_p  = 1'b1;
            ph_nxt = 3'd3;
          end
          3'd3: begin
            waddr  = bf_a;
            re_we  = 1'b1;
            im_we  = 1'b1;
            re_wd  = ur_r + tr;
            im_wd  = ui_r + ti;
            cap_t  = 1'b1;
            ph_nxt = 3'd4;
          end
          3'd4: begin
            waddr  = bf_b;
            re_we  = 1'b1;
            im_we  = 1'b1;
            re_wd  = ur_r - tr_r;
            im_wd  = ui_r - ti_r;
            ph_nxt = 3'd0;
            if (last_bf) begin
              cnt_nxt = '0;
              stg_nxt = stg_r + SW'(1);
            end else begin
              cnt_nxt = cnt_r + LW'(1);
            end
          end
          default: ph_nxt = 3'd0;
        endcase
      end
      ST_FILT: begin
        case (ph_r)
          3'd0: ph_nxt = 3'd1;
          3'd1: begin
            cap_p  = 1'b1;
            ph_nxt = 3'd2;
          end
          3'd2: begin
            re_we   = 1'b1;
            im_we   = 1'b1;
            re_wd   = rnd_a;
            im_wd   = rnd_b;
            ph_nxt  = 3'd0;
            cnt_nxt = cnt_r + LW'(1);
          end
          default: ph_nxt = 3'd0;
        endcase
      end
      ST_SCALE: begin
        if (ph_r == 3'd0) begin
          ph_nxt = 3'd1;
        end else begin
          tm_we   = 1'b1;
          ph_nxt  = 3'd0;
          cnt_nxt = cnt_r + LW'(1);
        end
      end
      default: ;
    endcase
  end

  // rams: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (re_we) real_mem[waddr] <= re_wd;
    if (im_we) imag_mem[waddr] <= im_wd;
    if (tm_we) time_mem[waddr] <= tm_wd;
    if (gn_we) gain_mem[waddr] <= gn_wd;
    re_rd_r <= real_mem[raddr];
    im_rd_r <= imag_mem[raddr];
    tm_rd_r <= time_mem[raddr];
    gn_rd_r <= gain_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rom_en) begin
      rom_c_r <= COS_ROM[tw_c];
      rom_s_r <= COS_ROM[tw_s];
    end
    if (cap_u) begin
      ur_r <= re_rd_r;
      ui_r <= im_rd_r;
    end
    if (cap_p) begin
      p_a_r <= mul_a;
      p_b_r <= mul_b;
      p_c_r <= mul_c;
      p_d_r <= mul_d;
    end
    if (cap_t) begin
      tr_r <= tr;
      ti_r <= ti;
    end
    if (accept) out_idx_r <= in_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= ST_CLEAR;
      cnt_r           <= '0;
      ph_r            <= 3'd0;
      stg_r           <= '0;
      inv_r           <= 1'b0;
      out_pend_r      <= 1'b0;
      sample_offset_r <= SAMPLE_OFFSET_RST;
    end else begin
      st_r       <= st_nxt;
      cnt_r      <= cnt_nxt;
      ph_r       <= ph_nxt;
      stg_r      <= stg_nxt;
      inv_r      <= inv_nxt;
      out_pend_r <= accept && (in_op == OP_READ);
      if (psel && penable && pwrite && pready && !paddr[2]) begin
        sample_offset_r <= pwdata[11:0];
      end
    end
  end

  assign out_valid      = out_pend_r;
  assign out_bin_index  = out_idx_r;
  assign out_real_part  = re_rd_r;
  assign out_imag_part  = im_rd_r;
  assign out_time_value = tm_rd_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {20'd0, sample_offset_r};

  `FFE_ASSERT(a_out_from_read, clk, rst_n, out_valid |-> $past(start && !busy && in_op == OP_READ), "result strobe without a read word")
  `FFE_NEVER(a_idle_phase, clk, rst_n, st_r == ST_IDLE && ph_r != 3'd0, "sequencer idle with a step pending")
  `FFE_ASSERT(a_perm_write, clk, rst_n, (st_r == ST_PERM && re_we) |-> (ph_r == 3'd2 || ph_r == 3'd3), "swap write outside its steps")

endmodule
